@@ hw/rtl/lome_pkg.sv @@
// Shared types, constants and codes for the order matching engine.
`timescale 1ns / 1ps
package lome_pkg;

  localparam int BOOK_SLOTS = 63;
  localparam int PRICE_BITS = 16;
  localparam int QTY_BITS   = 16;
  localparam int ID_BITS    = 32;
  localparam int SLOT_W     = $clog2(BOOK_SLOTS);
  localparam int CNT_W      = $clog2(BOOK_SLOTS + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BOOK_SLOTS - 1);
  localparam logic [CNT_W-1:0]  MAX_FILLS = CNT_W'(BOOK_SLOTS);

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;
  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;
  localparam logic REC_TRADE   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ST_OPEN    = 3'd0,
    ST_PARTIAL = 3'd1,
    ST_FILLED  = 3'd2,
    ST_CANCEL  = 3'd3,
    ST_DROPPED = 3'd4
  } ord_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_FILL,
    S_SUMMARY
  } ctrl_state_t;

  // one resting order as held in the book memory
  typedef struct packed {
    logic                  side;
    logic [ID_BITS-1:0]    ord_id;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   remaining;
    logic [31:0]           arrival;
  } slot_t;

  typedef struct packed {
    logic                  record_kind;
    logic [31:0]           trade_id;
    logic [ID_BITS-1:0]    buyer_id;
    logic [ID_BITS-1:0]    seller_id;
    logic [PRICE_BITS-1:0] trade_price;
    logic [QTY_BITS-1:0]   fill_qty;
    logic                  aggressor_side;
    ord_status_t           order_status;
    logic                  last_record;
  } out_rec_t;

  typedef struct packed {
    logic                  side;
    logic                  order_kind;
    logic [ID_BITS-1:0]    ord_id;
    logic [PRICE_BITS-1:0] limit_price;
    logic [QTY_BITS-1:0]   quantity;
  } in_rec_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic fill;
    logic summary;
  } dp_cmd_t;

  typedef struct packed {
    logic left_zero;
    logic scan_done;
    logic match_ok;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/lome_if.sv @@
// Valid/ready channel interfaces for incoming orders and result records.
`timescale 1ns / 1ps
interface lome_in_if;
  logic                            valid;
  logic                            ready;
  logic [lome_pkg::ID_BITS-1:0]    ord_id;
  logic                            side;
  logic                            order_kind;
  logic [lome_pkg::PRICE_BITS-1:0] limit_price;
  logic [lome_pkg::QTY_BITS-1:0]   quantity;
  modport source (output valid, ord_id, side, order_kind, limit_price, quantity,
                  input ready);
  modport sink (input valid, ord_id, side, order_kind, limit_price, quantity,
                output ready);
endinterface

interface lome_out_if;
  logic                            valid;
  logic                            ready;
  logic                            record_kind;
  logic [31:0]                     trade_id;
  logic [lome_pkg::ID_BITS-1:0]    buyer_id;
  logic [lome_pkg::ID_BITS-1:0]    seller_id;
  logic [lome_pkg::PRICE_BITS-1:0] trade_price;
  logic [lome_pkg::QTY_BITS-1:0]   fill_qty;
  logic                            aggressor_side;
  logic [2:0]                      order_status;
  logic                            last_record;
  modport source (output valid, record_kind, trade_id, buyer_id, seller_id, trade_price,
                  fill_qty, aggressor_side, order_status, last_record, input ready);
  modport sink (input valid, record_kind, trade_id, buyer_id, seller_id, trade_price,
                fill_qty, aggressor_side, order_status, last_record, output ready);
endinterface

@@ hw/rtl/lome_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lome_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/lome_ctrl.sv @@
// Sequencing state machine for matching one order.
`timescale 1ns / 1ps
module lome_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lome_pkg::dp_sts_t sts,
  output lome_pkg::dp_cmd_t cmd
);
  lome_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lome_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lome_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lome_pkg::S_CHECK;
      end
      lome_pkg::S_CHECK: begin
        state_nxt = sts.left_zero ? lome_pkg::S_SUMMARY : lome_pkg::S_SCAN;
      end
      lome_pkg::S_SCAN: begin
        if (sts.scan_done) state_nxt = lome_pkg::S_DECIDE;
      end
      lome_pkg::S_DECIDE: begin
        state_nxt = sts.match_ok ? lome_pkg::S_FILL : lome_pkg::S_SUMMARY;
      end
      lome_pkg::S_FILL: begin
        if (sts.out_free) state_nxt = lome_pkg::S_CHECK;
      end
      lome_pkg::S_SUMMARY: begin
        if (sts.out_free) state_nxt = lome_pkg::S_IDLE;
      end
      default: state_nxt = lome_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      lome_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lome_pkg::S_CHECK:   cmd.scan_start = !sts.left_zero;
      lome_pkg::S_FILL:    cmd.fill = sts.out_free;
      lome_pkg::S_SUMMARY: cmd.summary = sts.out_free;
      default: ;
    endcase
  end
endmodule

@@ hw/rtl/lome_dp.sv @@
// Datapath: book memory, slot scan, fill arithmetic and result register.
`timescale 1ns / 1ps
module lome_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lome_pkg::dp_cmd_t  cmd,
  output lome_pkg::dp_sts_t  sts,
  input  lome_pkg::in_rec_t  in_rec,
  output logic               out_valid,
  input  logic               out_ready,
  output lome_pkg::out_rec_t out_rec
);
  // incoming order
  lome_pkg::in_rec_t                ord_r;
  logic [lome_pkg::QTY_BITS-1:0]    left_r, filled_r;
  logic [lome_pkg::CNT_W-1:0]       fills_r;
  logic [31:0]                      arrival_r, trade_num_r;
  logic [lome_pkg::BOOK_SLOTS-1:0]  valid_r;

  // scan pipeline
  logic                             scan_on_r, p_act_r, p_vld_r;
  logic [lome_pkg::SLOT_W-1:0]      scan_idx_r, p_idx_r;
  logic                             have_best_r, free_found_r;
  logic [lome_pkg::SLOT_W-1:0]      best_idx_r, free_idx_r;
  lome_pkg::slot_t                  best_r;
  logic [31:0]                      best_age_r;

  // result register
  logic                             out_valid_r;
  lome_pkg::out_rec_t               out_r;

  lome_pkg::slot_t                  rd;
  logic                             we;
  logic [lome_pkg::SLOT_W-1:0]      waddr;
  lome_pkg::slot_t                  wdata;

  logic                             opp;
  logic [31:0]                      age;
  logic                             cand, better, crosses;
  logic [lome_pkg::QTY_BITS-1:0]    fill_q, new_rem;
  logic                             rests;
  lome_pkg::ord_status_t            sum_status;

  lome_ram #(
    .WIDTH ($bits(lome_pkg::slot_t)),
    .DEPTH (lome_pkg::BOOK_SLOTS)
  ) u_book (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_idx_r),
    .rdata (rd)
  );

  assign opp  = ~ord_r.side;
  assign age  = arrival_r - rd.arrival;
  assign cand = p_act_r && p_vld_r && (rd.side == opp);
  assign better = !have_best_r
               || (opp ? (rd.price < best_r.price) : (rd.price > best_r.price))
               || ((rd.price == best_r.price) && (age > best_age_r));

  assign crosses = (ord_r.order_kind == lome_pkg::KIND_MARKET)
                || (ord_r.side ? (ord_r.limit_price <= best_r.price)
                               : (ord_r.limit_price >= best_r.price));
  assign fill_q  = (left_r < best_r.remaining) ? left_r : best_r.remaining;
  assign new_rem = best_r.remaining - fill_q;

  // remainder rests only for a limit order with a free slot
  assign rests = (left_r != '0) && (ord_r.order_kind != lome_pkg::KIND_MARKET)
              && free_found_r;

  always_comb begin
    if (left_r == '0) begin
      sum_status = lome_pkg::ST_FILLED;
    end else if (ord_r.order_kind == lome_pkg::KIND_MARKET) begin
      sum_status = lome_pkg::ST_CANCEL;
    end else if (!free_found_r) begin
      sum_status = lome_pkg::ST_DROPPED;
    end else if (filled_r != '0) begin
      sum_status = lome_pkg::ST_PARTIAL;
    end else begin
      sum_status = lome_pkg::ST_OPEN;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = best_idx_r;
    wdata = best_r;
    if (cmd.fill) begin
      we              = 1'b1;
      wdata.remaining = new_rem;
    end else if (cmd.summary && rests) begin
      we        = 1'b1;
      waddr     = free_idx_r;
      wdata     = '{side: ord_r.side, ord_id: ord_r.ord_id, price: ord_r.limit_price,
                    remaining: left_r, arrival: arrival_r};
    end
  end

  assign sts.left_zero = (left_r == '0);
  assign sts.scan_done = p_act_r && (p_idx_r == lome_pkg::LAST_SLOT);
  assign sts.match_ok  = have_best_r && crosses && (fills_r < lome_pkg::MAX_FILLS);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_rec   = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      arrival_r    <= '0;
      trade_num_r  <= '0;
      scan_on_r    <= 1'b0;
      p_act_r      <= 1'b0;
      have_best_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      fills_r      <= '0;
    end else begin
      if (cmd.load) fills_r <= '0;

      if (cmd.scan_start) begin
        scan_on_r    <= 1'b1;
        have_best_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else if (scan_on_r && scan_idx_r == lome_pkg::LAST_SLOT) begin
        scan_on_r <= 1'b0;
      end
      p_act_r <= scan_on_r;

      if (scan_on_r && !valid_r[scan_idx_r] && !free_found_r) free_found_r <= 1'b1;
      if (cand && better) have_best_r <= 1'b1;

      if (cmd.fill) begin
        if (new_rem == '0) valid_r[best_idx_r] <= 1'b0;
        trade_num_r <= trade_num_r + 32'd1;
        fills_r     <= fills_r + lome_pkg::CNT_W'(1);
      end
      if (cmd.summary && rests) begin
        valid_r[free_idx_r] <= 1'b1;
        arrival_r           <= arrival_r + 32'd1;
      end

      if (cmd.fill || cmd.summary) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ord_r    <= in_rec;
      left_r   <= in_rec.quantity;
      filled_r <= '0;
    end
    if (cmd.scan_start) scan_idx_r <= '0;
    else if (scan_on_r && scan_idx_r != lome_pkg::LAST_SLOT)
      scan_idx_r <= scan_idx_r + lome_pkg::SLOT_W'(1);
    p_idx_r <= scan_idx_r;
    p_vld_r <= valid_r[scan_idx_r];
    if (scan_on_r && !valid_r[scan_idx_r] && !free_found_r) free_idx_r <= scan_idx_r;
    if (cand && better) begin
      best_r     <= rd;
      best_age_r <= age;
      best_idx_r <= p_idx_r;
    end
    if (cmd.fill) begin
      left_r   <= left_r - fill_q;
      filled_r <= filled_r + fill_q;
      out_r.record_kind    <= lome_pkg::REC_TRADE;
      out_r.trade_id       <= trade_num_r;
      out_r.buyer_id       <= ord_r.side ? best_r.ord_id : ord_r.ord_id;
      out_r.seller_id      <= ord_r.side ? ord_r.ord_id : best_r.ord_id;
      out_r.trade_price    <= best_r.price;
      out_r.fill_qty       <= fill_q;
      out_r.aggressor_side <= ord_r.side;
      out_r.order_status   <= (new_rem == '0) ? lome_pkg::ST_FILLED : lome_pkg::ST_PARTIAL;
      out_r.last_record    <= 1'b0;
    end else if (cmd.summary) begin
      out_r.record_kind    <= lome_pkg::REC_SUMMARY;
      out_r.trade_id       <= '0;
      out_r.buyer_id       <= ord_r.side ? '0 : ord_r.ord_id;
      out_r.seller_id      <= ord_r.side ? ord_r.ord_id : '0;
      out_r.trade_price    <= '0;
      out_r.fill_qty       <= filled_r;
      out_r.aggressor_side <= ord_r.side;
      out_r.order_status   <= sum_status;
      out_r.last_record    <= 1'b1;
    end
  end
endmodule

@@ hw/rtl/limit_order_matching_engine_unit.sv @@
// Top level of the price-time priority order matching engine.
`timescale 1ns / 1ps
//  channel | dir | word                                         | handshake
//  in_ch   | in  | ord_id, side, order_kind, limit_price, qty   | valid/ready
//  out_ch  | out | trade or summary record, last_record on end  | valid/ready
//
//  One order at a time. A book scan reads a slot a cycle and compares each slot once its
//  read data is registered. Each fill steps through check, scan, decide and fill.
//  The close is check then summary once qty runs out, else check, scan, decide and
//  summary; the idle state accepts the order first. Zero qty: accept, check, summary.
//  Reset (rst_n low, synchronous) empties the book at once through per-slot
//  valid flops and clears the arrival and trade counters. A stalled out_ch holds
//  fill/summary in place; the result register lets the next scan run while a word waits.
module limit_order_matching_engine_unit (
  input logic       clk,
  input logic       rst_n,
  lome_in_if.sink   in_ch,
  lome_out_if.source out_ch
);
  lome_pkg::dp_cmd_t  cmd;
  lome_pkg::dp_sts_t  sts;
  lome_pkg::in_rec_t  in_rec;
  lome_pkg::out_rec_t out_rec;

  // pack the input word
  assign in_rec.side        = in_ch.side;
  assign in_rec.order_kind  = in_ch.order_kind;
  assign in_rec.ord_id      = in_ch.ord_id;
  assign in_rec.limit_price = in_ch.limit_price;
  assign in_rec.quantity    = in_ch.quantity;

  // sequencer: accepts an order only when idle
  lome_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // book memory, scan and fill arithmetic
  lome_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_rec    (in_rec),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rec   (out_rec)
  );

  // unpack the result word
  assign out_ch.record_kind    = out_rec.record_kind;
  assign out_ch.trade_id       = out_rec.trade_id;
  assign out_ch.buyer_id       = out_rec.buyer_id;
  assign out_ch.seller_id      = out_rec.seller_id;
  assign out_ch.trade_price    = out_rec.trade_price;
  assign out_ch.fill_qty       = out_rec.fill_qty;
  assign out_ch.aggressor_side = out_rec.aggressor_side;
  assign out_ch.order_status   = out_rec.order_status;
  assign out_ch.last_record    = out_rec.last_record;

`ifndef SYNTHESIS
  // a trade record never closes an order
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.record_kind == lome_pkg::REC_TRADE) |-> !out_ch.last_record)
    else $error("trade record flagged last");

  // one order at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second order taken while busy");

  // fills only happen while quantity remains
  a_fill_needs_qty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> !sts.left_zero && sts.match_ok)
    else $error("fill without remaining quantity");

  // never two emits at once
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.fill && cmd.summary))
    else $error("trade and summary emitted together");
`endif
endmodule
